[sv/wgp_pkg.sv]
// ----------------------------------------------------------------------------
// wgp_pkg
// Shared defaults, codes and state type of the wavefront grid planner.
// ----------------------------------------------------------------------------
package wgp_pkg;

	// default geometry and distance cap
	localparam int GRID_W_DEF   = 32;
	localparam int GRID_H_DEF   = 32;
	localparam int MAX_DIST_DEF = 30;

	// reported distance for unreached or outside cells
	localparam int OUT_FAR = 31;

	// command codes
	localparam logic CMD_OBSTACLE = 1'b0;
	localparam logic CMD_QUERY    = 1'b1;

	// configuration register indexes
	localparam logic [0:0] REG_DEST_X = 1'b0;
	localparam logic [0:0] REG_DEST_Y = 1'b1;

	// rebuild neighbour directions
	localparam logic [2:0] DIR_XP = 3'd0;
	localparam logic [2:0] DIR_XM = 3'd1;
	localparam logic [2:0] DIR_YP = 3'd2;
	localparam logic [2:0] DIR_YM = 3'd3;

	// query slots: the cell itself, then up, left, right, down
	localparam logic [2:0] SLOT_SELF  = 3'd0;
	localparam logic [2:0] SLOT_UP    = 3'd1;
	localparam logic [2:0] SLOT_LEFT  = 3'd2;
	localparam logic [2:0] SLOT_RIGHT = 3'd3;
	localparam logic [2:0] SLOT_DOWN  = 3'd4;

	// sequencer states
	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_OBS_RD   = 11'b000_0000_0010,
		S_CLR      = 11'b000_0000_0100,
		S_SEED_CHK = 11'b000_0000_1000,
		S_POP      = 11'b000_0001_0000,
		S_POP_WAIT = 11'b000_0010_0000,
		S_NB_RD    = 11'b000_0100_0000,
		S_NB_CHK   = 11'b000_1000_0000,
		S_Q_RD     = 11'b001_0000_0000,
		S_Q_CHK    = 11'b010_0000_0000,
		S_OUT      = 11'b100_0000_0000
	} state_t;

endpackage

[sv/wgp_ram.sv]
// ----------------------------------------------------------------------------
// wgp_ram
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module wgp_ram
	import wgp_pkg::*;
#(
	parameter int DEPTH = GRID_W_DEF * GRID_H_DEF,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/wgp_obs_mem.sv]
// ----------------------------------------------------------------------------
// wgp_obs_mem
// Obstacle bitmap stored one column per word, two registered read ports.
// A column never written reads as free.
// ----------------------------------------------------------------------------
module wgp_obs_mem
	import wgp_pkg::*;
#(
	parameter int GRID_W = GRID_W_DEF,
	parameter int GRID_H = GRID_H_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [$clog2(GRID_W)-1:0] waddr,
	input  logic [GRID_H-1:0]         wdata,
	input  logic [$clog2(GRID_W)-1:0] raddr_a,
	input  logic [$clog2(GRID_W)-1:0] raddr_b,
	output logic [GRID_H-1:0]         rdata_a,
	output logic [GRID_H-1:0]         rdata_b
);

	logic [GRID_H-1:0] mem [GRID_W];
	logic [GRID_W-1:0] col_vld_q;

	// write a column
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// mark written columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_vld_q <= '0;
		end else if (we) begin
			col_vld_q[waddr] <= 1'b1;
		end
	end

	// registered reads, unwritten columns free
	always_ff @(posedge clk) begin
		rdata_a <= col_vld_q[raddr_a] ? mem[raddr_a] : '0;
		rdata_b <= col_vld_q[raddr_b] ? mem[raddr_b] : '0;
	end

endmodule

[sv/wavefront_grid_planner.sv]
// Query: after acceptance five distance slots are taken in turn; an in-range slot is read
// and then checked, an out-of-range slot is skipped, and last the output word is loaded.
// Obstacle: a column read if in range, then the result; a new obstacle then starts a map rebuild.
// Rebuild: a clearing sweep over all (GRID_W-1)*(GRID_H-1) distance cells, then a breadth-first
// pass that reads the neighbours of each reached cell in turn; no word is taken meanwhile.
// Reset: destination 1,1, no obstacles; a rebuild runs straight after reset (first a sweep of
// ----------------------------------------------------------------------------
// wavefront_grid_planner
// Obstacle bitmap, wavefront distance map and breadth-first rebuild sequencer.
// clearing writes to every distance map cell) and input stays stalled until it ends.
// ----------------------------------------------------------------------------
module wavefront_grid_planner
	import wgp_pkg::*;
#(
	parameter int GRID_W   = GRID_W_DEF,
	parameter int GRID_H   = GRID_H_DEF,
	parameter int MAX_DIST = MAX_DIST_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [4:0] cell_x,
	input  logic [4:0] cell_y,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] distance,
	output logic       at_destination,
	output logic [4:0] next_x,
	output logic [4:0] next_y,
	output logic       next_valid,
	output logic       obstacle_added
);

	localparam int HW     = GRID_W - 1;
	localparam int HH     = GRID_H - 1;
	localparam int HCELLS = HW * HH;
	localparam int XW     = $clog2(GRID_W);
	localparam int YW     = $clog2(GRID_H);
	localparam int DW     = $clog2(MAX_DIST + 2);
	localparam int AW     = $clog2(HCELLS);
	localparam int QPW    = $clog2(HCELLS + 1);
	localparam int QEW    = XW + YW + DW;
	localparam logic [DW-1:0] UNR = {DW{1'b1}};

	// distance map cell index
	function automatic logic [AW-1:0] cell_idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
		cell_idx = AW'(x) * AW'(HH) + AW'(y);
	endfunction

	// a cell is free when its four corner obstacle cells are free
	function automatic logic corner_free(input logic [GRID_H-1:0] ca,
		input logic [GRID_H-1:0] cb, input logic [YW-1:0] hy);
		logic [YW-1:0] hy1;
		hy1 = YW'(hy + 1'b1);
		corner_free = !ca[hy] && !ca[hy1] && !cb[hy] && !cb[hy1];
	endfunction

	state_t          state_q;
	logic            pend_q;
	logic [4:0]      dest_x_q, dest_y_q;
	logic [AW-1:0]   cnt_q;
	logic [QPW-1:0]  head_q, tail_q;
	logic [XW-1:0]   cur_x_q, nb_x_q, ox_q;
	logic [YW-1:0]   cur_y_q, nb_y_q, oy_q;
	logic [DW-1:0]   cur_d_q, best_q;
	logic [2:0]      k_q;
	logic [4:0]      q_x_q, q_y_q;
	logic [4:0]      res_dist_q, res_nx_q, res_ny_q;
	logic            res_atd_q, res_nv_q, res_add_q;
	logic            out_valid_q;
	logic [4:0]      distance_q, next_x_q, next_y_q;
	logic            at_dest_q, next_valid_q, added_q;

	// memory ports
	logic              dm_we;
	logic [AW-1:0]     dm_waddr, dm_raddr;
	logic [DW-1:0]     dm_wdata, dist_rd;
	logic              qm_we;
	logic [AW-1:0]     qm_waddr, qm_raddr;
	logic [QEW-1:0]    qm_wdata, q_rd;
	logic              om_we;
	logic [XW-1:0]     om_waddr, om_ra, om_rb;
	logic [GRID_H-1:0] om_wdata, col_a, col_b;

	// combinational helpers
	logic [XW-1:0] seed_hx, nbx;
	logic [YW-1:0] seed_hy, nby;
	logic          dest_ok, nb_ok, nb_free, seed_free, push, in_acc, out_load;
	logic [DW-1:0] nd, q_rd_d;
	logic [5:0]    sx, sy;
	logic          s_ok;
	logic [4:0]    dist_sat;

	wgp_ram #(.DEPTH(HCELLS), .WIDTH(DW)) u_dist_mem (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.raddr(dm_raddr), .rdata(dist_rd)
	);

	wgp_ram #(.DEPTH(HCELLS), .WIDTH(QEW)) u_queue_mem (
		.clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
		.raddr(qm_raddr), .rdata(q_rd)
	);

	wgp_obs_mem #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_obs_mem (
		.clk(clk), .arst_n(arst_n), .we(om_we), .waddr(om_waddr), .wdata(om_wdata),
		.raddr_a(om_ra), .raddr_b(om_rb), .rdata_a(col_a), .rdata_b(col_b)
	);

	// seed cell from the destination corner
	assign dest_ok   = (dest_x_q != 5'd0) && (int'(dest_x_q) <= HW) &&
	                   (dest_y_q != 5'd0) && (int'(dest_y_q) <= HH);
	assign seed_hx   = XW'(dest_x_q - 5'd1);
	assign seed_hy   = YW'(dest_y_q - 5'd1);
	assign seed_free = corner_free(col_a, col_b, cur_y_q);
	assign nb_free   = corner_free(col_a, col_b, nb_y_q);
	assign nd        = DW'(cur_d_q + 1'b1);
	assign q_rd_d    = q_rd[DW-1:0];
	assign push      = (dist_rd == UNR) && nb_free;

	// rebuild neighbour of the current cell
	always_comb begin
		nbx   = cur_x_q;
		nby   = cur_y_q;
		nb_ok = 1'b0;
		case (k_q)
			DIR_XP: begin
				nbx   = XW'(cur_x_q + 1'b1);
				nb_ok = int'(cur_x_q) != HW - 1;
			end
			DIR_XM: begin
				nbx   = XW'(cur_x_q - 1'b1);
				nb_ok = cur_x_q != '0;
			end
			DIR_YP: begin
				nby   = YW'(cur_y_q + 1'b1);
				nb_ok = int'(cur_y_q) != HH - 1;
			end
			DIR_YM: begin
				nby   = YW'(cur_y_q - 1'b1);
				nb_ok = cur_y_q != '0;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// query slot coordinates
	always_comb begin
		sx   = {1'b0, q_x_q};
		sy   = {1'b0, q_y_q};
		s_ok = 1'b1;
		case (k_q)
			SLOT_UP:    sy = 6'(q_y_q) + 6'd1;
			SLOT_LEFT: begin
				sx   = 6'(q_x_q) - 6'd1;
				s_ok = q_x_q != 5'd0;
			end
			SLOT_RIGHT: sx = 6'(q_x_q) + 6'd1;
			SLOT_DOWN: begin
				sy   = 6'(q_y_q) - 6'd1;
				s_ok = q_y_q != 5'd0;
			end
			default: s_ok = 1'b1;
		endcase
		s_ok = s_ok && (int'(sx) < HW) && (int'(sy) < HH);
	end

	assign dist_sat = (int'(dist_rd) > OUT_FAR) ? 5'(OUT_FAR) : 5'(dist_rd);

	// handshakes
	assign in_stall = (state_q != S_IDLE) || pend_q || cfg_we;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// memory address and write steering
	always_comb begin
		dm_we    = 1'b0;
		dm_waddr = cnt_q;
		dm_wdata = UNR;
		dm_raddr = cell_idx(nbx, nby);
		qm_we    = 1'b0;
		qm_waddr = AW'(tail_q);
		qm_wdata = {nb_x_q, nb_y_q, nd};
		qm_raddr = AW'(head_q);
		om_we    = 1'b0;
		om_waddr = ox_q;
		om_wdata = col_a | (GRID_H'(1) << oy_q);
		om_ra    = nbx;
		om_rb    = XW'(nbx + 1'b1);
		unique case (state_q)
			S_IDLE: begin
				om_ra = XW'(cell_x);
			end
			S_OBS_RD: begin
				om_we = !col_a[oy_q];
			end
			S_CLR: begin
				dm_we = 1'b1;
				om_ra = seed_hx;
				om_rb = XW'(seed_hx + 1'b1);
			end
			S_SEED_CHK: begin
				dm_we    = seed_free;
				dm_waddr = cell_idx(cur_x_q, cur_y_q);
				dm_wdata = '0;
				qm_we    = seed_free;
				qm_waddr = '0;
				qm_wdata = {cur_x_q, cur_y_q, {DW{1'b0}}};
			end
			S_NB_CHK: begin
				dm_we    = push;
				dm_waddr = cell_idx(nb_x_q, nb_y_q);
				dm_wdata = nd;
				qm_we    = push;
			end
			S_Q_RD: begin
				dm_raddr = cell_idx(XW'(sx), YW'(sy));
			end
			S_POP, S_POP_WAIT, S_NB_RD, S_Q_CHK, S_OUT: begin
				dm_we = 1'b0;
			end
			default: begin
				dm_we = 1'b0;
			end
		endcase
	end

	// request a rebuild after a new obstacle or a destination write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cfg_we) begin
			pend_q <= 1'b1;
		end else if (state_q == S_OBS_RD && !col_a[oy_q]) begin
			pend_q <= 1'b1;
		end else if (state_q == S_IDLE) begin
			pend_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			cnt_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			k_q      <= '0;
			dest_x_q <= 5'd1;
			dest_y_q <= 5'd1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						cnt_q   <= '0;
						state_q <= S_CLR;
					end else if (in_acc) begin
						if (command == CMD_QUERY) begin
							k_q     <= SLOT_SELF;
							state_q <= S_Q_RD;
						end else if (int'(cell_x) < GRID_W && int'(cell_y) < GRID_H) begin
							state_q <= S_OBS_RD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OBS_RD: begin
					state_q <= S_OUT;
				end
				S_CLR: begin
					cnt_q <= AW'(cnt_q + 1'b1);
					if (int'(cnt_q) == HCELLS - 1) begin
						cur_x_q <= seed_hx;
						cur_y_q <= seed_hy;
						state_q <= dest_ok ? S_SEED_CHK : S_IDLE;
					end
				end
				S_SEED_CHK: begin
					head_q  <= '0;
					tail_q  <= QPW'(1);
					state_q <= seed_free ? S_POP : S_IDLE;
				end
				S_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_IDLE;
					end else begin
						head_q  <= QPW'(head_q + 1'b1);
						state_q <= S_POP_WAIT;
					end
				end
				S_POP_WAIT: begin
					cur_x_q <= q_rd[QEW-1 -: XW];
					cur_y_q <= q_rd[DW +: YW];
					cur_d_q <= q_rd_d;
					k_q     <= DIR_XP;
					state_q <= (int'(q_rd_d) >= MAX_DIST) ? S_POP : S_NB_RD;
				end
				S_NB_RD: begin
					if (nb_ok) begin
						nb_x_q  <= nbx;
						nb_y_q  <= nby;
						state_q <= S_NB_CHK;
					end else if (k_q == DIR_YM) begin
						state_q <= S_POP;
					end else begin
						k_q <= 3'(k_q + 1'b1);
					end
				end
				S_NB_CHK: begin
					if (push) begin
						tail_q <= QPW'(tail_q + 1'b1);
					end
					if (k_q == DIR_YM) begin
						state_q <= S_POP;
					end else begin
						k_q     <= 3'(k_q + 1'b1);
						state_q <= S_NB_RD;
					end
				end
				S_Q_RD: begin
					if (s_ok) begin
						state_q <= S_Q_CHK;
					end else if (k_q == SLOT_DOWN) begin
						state_q <= S_OUT;
					end else begin
						k_q <= 3'(k_q + 1'b1);
					end
				end
				S_Q_CHK: begin
					if (k_q == SLOT_DOWN) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= 3'(k_q + 1'b1);
						state_q <= S_Q_RD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// configuration writes restart the rebuild
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DEST_X: dest_x_q <= cfg_data;
					REG_DEST_Y: dest_y_q <= cfg_data;
					default:    dest_x_q <= dest_x_q;
				endcase
			end
		end
	end

	// result word build-up
	always_ff @(posedge clk) begin
		if (in_acc) begin
			q_x_q      <= cell_x;
			q_y_q      <= cell_y;
			ox_q       <= XW'(cell_x);
			oy_q       <= YW'(cell_y);
			res_dist_q <= 5'(OUT_FAR);
			res_atd_q  <= 1'b0;
			res_nx_q   <= 5'd0;
			res_ny_q   <= 5'd0;
			res_nv_q   <= 1'b0;
			res_add_q  <= 1'b0;
		end
		if (state_q == S_OBS_RD) begin
			res_add_q <= !col_a[oy_q];
		end
		if (state_q == S_Q_CHK && dist_rd != UNR) begin
			if (k_q == SLOT_SELF) begin
				res_dist_q <= dist_sat;
				res_atd_q  <= dist_rd == '0;
			end else if (!res_nv_q || dist_rd < best_q) begin
				best_q   <= dist_rd;
				res_nv_q <= 1'b1;
				res_nx_q <= sx[4:0];
				res_ny_q <= sy[4:0];
			end
		end
		if (out_load) begin
			distance_q   <= res_dist_q;
			at_dest_q    <= res_atd_q;
			next_x_q     <= res_nx_q;
			next_y_q     <= res_ny_q;
			next_valid_q <= res_nv_q;
			added_q      <= res_add_q;
		end
	end

	// output word valid: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign distance       = distance_q;
	assign at_destination = at_dest_q;
	assign next_x         = next_x_q;
	assign next_y         = next_y_q;
	assign next_valid     = next_valid_q;
	assign obstacle_added = added_q;

endmodule

[sim/wavefront_grid_planner_tb.sv]
// ----------------------------------------------------------------------------
// wavefront_grid_planner_tb
// Drives obstacle and query words into the planner under random idling, keeps
// its own obstacle bitmap and wavefront distance map, and checks every result.
// ----------------------------------------------------------------------------
module wavefront_grid_planner_tb;
	import wgp_pkg::*;

	localparam int GW   = 32;
	localparam int GH   = 32;
	localparam int HW   = GW - 1;
	localparam int HH   = GH - 1;
	localparam int MAXD = 30;
	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [4:0] distance;
		logic       at_dest;
		logic [4:0] nx;
		logic [4:0] ny;
		logic       nv;
		logic       added;
	} nav_word_t;

	class nav_scoreboard;
		bit        obst [GW][GH];
		bit        reach [HW][HH];
		int        dmap [HW][HH];
		int        dx, dy;
		nav_word_t pending [$];
		int        errors;

		function new();
			errors = 0;
			dx = 1;
			dy = 1;
			foreach (obst[i, j]) obst[i][j] = 0;
			rebuild_map();
		endfunction

		function bit corner_free(int hx, int hy);
			return !obst[hx+1][hy+1] && !obst[hx+1][hy] && !obst[hx][hy+1] && !obst[hx][hy];
		endfunction

		// breadth-first wavefront from the destination, capped at MAXD
		function void rebuild_map();
			int fifo [$];
			int cur, cx, cy, nx, ny, k;
			int stx [4] = '{1, -1, 0, 0};
			int sty [4] = '{0, 0, 1, -1};
			foreach (reach[i, j]) begin
				reach[i][j] = 0;
				dmap[i][j] = 0;
			end
			if (dx < 1 || dx > HW || dy < 1 || dy > HH) return;
			if (!corner_free(dx - 1, dy - 1)) return;
			reach[dx-1][dy-1] = 1;
			fifo.push_back((dx - 1) * HH + dy - 1);
			while (fifo.size() > 0) begin
				cur = fifo.pop_front();
				cx = cur / HH;
				cy = cur % HH;
				if (dmap[cx][cy] + 1 > MAXD) continue;
				for (k = 0; k < 4; k++) begin
					nx = cx + stx[k];
					ny = cy + sty[k];
					if (nx < 0 || ny < 0 || nx >= HW || ny >= HH) continue;
					if (reach[nx][ny] || !corner_free(nx, ny)) continue;
					reach[nx][ny] = 1;
					dmap[nx][ny] = dmap[cx][cy] + 1;
					fifo.push_back(nx * HH + ny);
				end
			end
		endfunction

		function void set_dest(logic [0:0] idx, logic [4:0] v);
			if (idx == REG_DEST_X) dx = int'(v);
			else dy = int'(v);
			rebuild_map();
		endfunction

		// note an accepted word and queue the result it must produce
		function void note_word(logic cmd, logic [4:0] x, logic [4:0] y);
			nav_word_t r;
			int qx [4] = '{0, -1, 1, 0};
			int qy [4] = '{1, 0, 0, -1};
			int k, cx, cy, best;
			r = '{distance: 5'(OUT_FAR), default: '0};
			if (cmd == CMD_OBSTACLE) begin
				if (!obst[x][y]) begin
					obst[x][y] = 1;
					r.added = 1;
					rebuild_map();
				end
			end else begin
				if (x < HW && y < HH && reach[x][y]) begin
					r.distance = 5'(dmap[x][y]);
					r.at_dest = dmap[x][y] == 0;
				end
				best = 0;
				for (k = 0; k < 4; k++) begin
					cx = int'(x) + qx[k];
					cy = int'(y) + qy[k];
					if (cx < 0 || cy < 0 || cx >= HW || cy >= HH) continue;
					if (!reach[cx][cy]) continue;
					if (r.nv && dmap[cx][cy] >= best) continue;
					best = dmap[cx][cy];
					r.nv = 1;
					r.nx = 5'(cx);
					r.ny = 5'(cy);
				end
			end
			pending.push_back(r);
		endfunction

		function void check_word(nav_word_t got);
			nav_word_t exp_w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.distance !== exp_w.distance) report("distance", exp_w.distance, got.distance);
			if (got.at_dest !== exp_w.at_dest)
				report("at_destination", 5'(exp_w.at_dest), 5'(got.at_dest));
			if (got.nx !== exp_w.nx) report("next_x", exp_w.nx, got.nx);
			if (got.ny !== exp_w.ny) report("next_y", exp_w.ny, got.ny);
			if (got.nv !== exp_w.nv) report("next_valid", 5'(exp_w.nv), 5'(got.nv));
			if (got.added !== exp_w.added)
				report("obstacle_added", 5'(exp_w.added), 5'(got.added));
		endfunction

		function void report(string fld, logic [4:0] e, logic [4:0] a);
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, e, a);
			errors++;
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic [0:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;
	logic       in_valid = 0;
	logic       in_stall;
	logic       command = 0;
	logic [4:0] cell_x = '0;
	logic [4:0] cell_y = '0;
	logic       out_valid;
	logic       out_stall = 0;
	logic [4:0] distance;
	logic       at_destination;
	logic [4:0] next_x;
	logic [4:0] next_y;
	logic       next_valid;
	logic       obstacle_added;

	nav_scoreboard board = new();
	int  send_idle_pct = 13;
	int  recv_idle_pct = 77;
	bit  hold_recv = 0;
	int  idle_cycles = 0;
	int  words_sent = 0;
	int  queries_sent = 0;

	wavefront_grid_planner DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// sample results at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word({distance, at_destination, next_x, next_y, next_valid,
				obstacle_added});
	end

	// receiver stall, drawn at the falling edge
	always @(negedge clk) begin
		out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// offer one word and hold it until taken; valid drops on idling or drain
	task automatic send_word(logic cmd, int x, int y);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		cell_x <= 5'(x);
		cell_y <= 5'(y);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_word(cmd, 5'(x), 5'(y));
		words_sent++;
		if (cmd == CMD_QUERY) queries_sent++;
		@(negedge clk);
	endtask

	// wait until every result is in, then idle to give any rebuild time to run
	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() > 0) @(negedge clk);
		repeat (4000) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 5'(v);
		@(negedge clk);
		cfg_we <= 0;
		board.set_dest(idx, 5'(v));
		@(negedge clk);
	endtask

	// mostly queries near the destination; some obstacles, some anywhere
	task automatic random_words(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 2)
				send_word(CMD_OBSTACLE, int'(5'($urandom)), int'(5'($urandom)));
			else if ($urandom_range(3) == 0)
				send_word(CMD_QUERY, int'(5'($urandom)), int'(5'($urandom)));
			else
				send_word(CMD_QUERY, int'(5'(board.dx - 1 + $urandom_range(6) - 3)),
					int'(5'(board.dy - 1 + $urandom_range(6) - 3)));
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1;
		drain();

		// directed: default destination corner, edges, obstacles
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_QUERY, 1, 0);
		send_word(CMD_QUERY, 0, 1);
		send_word(CMD_QUERY, 30, 30);
		send_word(CMD_QUERY, 31, 31);
		send_word(CMD_QUERY, 31, 5);
		send_word(CMD_QUERY, 5, 31);
		send_word(CMD_QUERY, 29, 1);
		send_word(CMD_OBSTACLE, 31, 31);
		send_word(CMD_OBSTACLE, 31, 31);
		send_word(CMD_OBSTACLE, 2, 2);
		send_word(CMD_QUERY, 1, 1);
		send_word(CMD_QUERY, 2, 1);
		send_word(CMD_OBSTACLE, 0, 0);
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_QUERY, 1, 0);
		drain();

		// destination at the far corner and out of range
		write_reg(REG_DEST_X, 31);
		write_reg(REG_DEST_Y, 31);
		drain();
		send_word(CMD_QUERY, 30, 30);
		send_word(CMD_QUERY, 29, 30);
		send_word(CMD_QUERY, 0, 0);
		drain();
		write_reg(REG_DEST_X, 0);
		drain();
		send_word(CMD_QUERY, 30, 30);
		send_word(CMD_QUERY, 0, 30);
		drain();
		write_reg(REG_DEST_X, 16);
		write_reg(REG_DEST_Y, 15);
		drain();
		random_words(45);

		// hold the receiver off while words keep coming
		hold_recv = 1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_recv = 0;
			end
			random_words(10);
		join
		drain();

		send_idle_pct = 77;
		recv_idle_pct = 13;
		write_reg(REG_DEST_X, 5);
		write_reg(REG_DEST_Y, 27);
		drain();
		random_words(40);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_DEST_X, 1);
		write_reg(REG_DEST_Y, 0);
		drain();
		random_words(5);
		drain();
		write_reg(REG_DEST_Y, 30);
		drain();
		random_words(30);
		drain();

		$display("Covered %0d words (%0d queries), destinations at corners, edges, outside.",
			words_sent, queries_sent);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
